>>> design/bmpw_pkg.sv
// package: shared types and constants of the 24-bit bmp stream writer
`default_nettype none

package bmpw_pkg;

   // field widths
   localparam int DIM_W    = 13;
   localparam int COL_W    = 12;
   localparam int STRIDE_W = 14;
   localparam int RAW_W    = 27;
   localparam int IDX_W    = 6;

   // largest accepted width or height
   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

   // register indexes of the csr port
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // reset values of the registers
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

   // transfer queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // header layout
   localparam logic [IDX_W-1:0] HDR_LAST   = 6'd53;
   localparam logic [IDX_W-1:0] OFS_MAGIC0 = 6'd0;
   localparam logic [IDX_W-1:0] OFS_MAGIC1 = 6'd1;
   localparam logic [IDX_W-1:0] OFS_FSIZE  = 6'd2;
   localparam logic [IDX_W-1:0] OFS_OFFSET = 6'd10;
   localparam logic [IDX_W-1:0] OFS_INFO   = 6'd14;
   localparam logic [IDX_W-1:0] OFS_WIDTH  = 6'd18;
   localparam logic [IDX_W-1:0] OFS_HEIGHT = 6'd22;
   localparam logic [IDX_W-1:0] OFS_PLANES = 6'd26;
   localparam logic [IDX_W-1:0] OFS_BPP    = 6'd28;
   localparam logic [IDX_W-1:0] OFS_RAW    = 6'd34;
   localparam logic [IDX_W-1:0] OFS_XRES   = 6'd38;
   localparam logic [IDX_W-1:0] OFS_YRES   = 6'd42;

   // header byte values
   localparam logic [7:0]  MAGIC_B    = 8'h42;
   localparam logic [7:0]  MAGIC_M    = 8'h4D;
   localparam logic [7:0]  DATA_OFS   = 8'h36;
   localparam logic [7:0]  INFO_SIZE  = 8'h28;
   localparam logic [7:0]  PLANES     = 8'h01;
   localparam logic [7:0]  BITS_PIXEL = 8'h18;
   localparam logic [31:0] RES_PPM    = 32'h0000_0B13;
   localparam logic [31:0] HDR_BYTES  = 32'd54;

   // one classified pixel, as queued from front to back
   typedef struct packed {
      logic [7:0]          blue;
      logic [7:0]          green;
      logic [7:0]          red;
      logic                header;
      logic                row_end;
      logic                frame_end;
      logic [1:0]          pad;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [STRIDE_W-1:0] stride;
   } entry_type;

   // handshake between queue and back
   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

endpackage

`default_nettype wire

>>> design/bmp_24bit_stream_writer_unit.sv
// top level: 24-bit bmp stream writer, front classifier, queue and byte sequencer
//
// Usage:
//   req channel takes one pixel per transaction, tdata = {red, green, blue},
//   in file order (bottom row first, left to right).
//   rsp channel gives one file byte per transaction; tlast marks the final
//   byte caused by a pixel, tuser marks the final byte of the whole file.
//   csr channel writes image_width (index 0) or image_height (index 1); it is
//   always ready; the user must write it only while the block is idle (not enforced).
// Path: a taken pixel is queued, loaded as the current entry, then its first byte is registered.
// Throughput: one byte per cycle while rsp_tready is high, set by the single output byte
//   register; a pixel gives 3 bytes, plus 54 header bytes at a frame start and up to
//   3 pad bytes at a row end.
// The four-entry queue lets req keep being taken while the output waits.
// Reset clears the counters and queue, and sets the registers to 640 x 480.
// When rsp_tready is low the current byte holds and the sequencer waits;
//   req_tready drops once the queue is full.
`default_nettype none

module bmp_24bit_stream_writer_unit (
   input  wire        clock,
   input  wire        reset,
   // pixel input: [7:0] blue, [15:8] green, [23:16] red
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [23:0] req_tdata,
   // byte output: [7:0] out_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   // rsp_tuser: [0] end_of_file
   output logic       rsp_tuser,
   // register writes
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_index,
   input  wire [12:0] csr_data
);
   import bmpw_pkg::*;

   entry_type front_entry;
   entry_type head_entry;
   link_type  head_link;
   logic      queue_full;
   logic      pop;
   logic      in_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign in_accept  = req_tvalid && req_tready;

   bmpw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_accept (in_accept),
      .in_pixel  (req_tdata),
      .entry     (front_entry)
   );

   bmpw_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (in_accept),
      .push_entry    (front_entry),
      .full          (queue_full),
      .head_link_out (head_link),
      .pop           (pop),
      .head_entry    (head_entry)
   );

   bmpw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_link  (head_link),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_eof    (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> design/bmpw_front.sv
// front: config registers, row/column counters and pixel classification
`default_nettype none

module bmpw_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_valid,
   input  wire                     csr_index,
   input  wire [12:0]              csr_data,
   input  wire                     in_accept,
   input  wire [23:0]              in_pixel,
   output bmpw_pkg::entry_type     entry
);
   import bmpw_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic             hdr_sent_ff, hdr_sent_in;

   logic [DIM_W-1:0] w_clamp;
   logic [DIM_W-1:0] h_clamp;
   logic [DIM_W:0]   row_next;
   logic [DIM_W-1:0] col_next;
   logic             row_end;
   logic             frame_end;

   // config register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         if (csr_index == CSR_IMAGE_WIDTH) width_in = csr_data;
         else height_in = csr_data;
      end
   end

   // clamp dimensions into 1..MAX_DIM
   always_comb begin
      if (width_ff == '0) w_clamp = DIM_W'(1);
      else if (width_ff > MAX_DIM) w_clamp = MAX_DIM;
      else w_clamp = width_ff;
      if (height_ff == '0) h_clamp = DIM_W'(1);
      else if (height_ff > MAX_DIM) h_clamp = MAX_DIM;
      else h_clamp = height_ff;
   end

   // row and frame end detection
   assign col_next  = {1'b0, col_ff} + DIM_W'(1);
   assign row_next  = {1'b0, row_ff} + (DIM_W+1)'(1);
   assign row_end   = (col_next >= w_clamp);
   assign frame_end = row_end && (row_next >= {1'b0, h_clamp});

   // counter update on each accepted pixel
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      hdr_sent_in = hdr_sent_ff;
      if (in_accept) begin
         hdr_sent_in = !frame_end;
         if (row_end) begin
            col_in = '0;
            if (frame_end) row_in = '0;
            else row_in = row_next[DIM_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         hdr_sent_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         hdr_sent_ff <= hdr_sent_in;
      end
   end

   // classified entry for the queue
   always_comb begin
      entry.blue      = in_pixel[7:0];
      entry.green     = in_pixel[15:8];
      entry.red       = in_pixel[23:16];
      entry.header    = !hdr_sent_ff;
      entry.row_end   = row_end;
      entry.frame_end = frame_end;
      // 3w mod 4 is -w mod 4, so the padding is w mod 4
      entry.pad       = w_clamp[1:0];
      entry.width     = w_clamp;
      entry.height    = h_clamp;
      entry.stride    = STRIDE_W'({w_clamp, 1'b0}) + STRIDE_W'(w_clamp)
                        + STRIDE_W'(w_clamp[1:0]);
   end

endmodule

`default_nettype wire

>>> design/bmpw_queue.sv
// queue: short fifo of classified pixels between front and back
`default_nettype none

module bmpw_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  bmpw_pkg::entry_type push_entry,
   output logic                full,
   output bmpw_pkg::link_type  head_link_out,
   input  wire                 pop,
   output bmpw_pkg::entry_type head_entry
);
   import bmpw_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && (count_ff != '0);

   assign head_link_out.valid = (count_ff != '0);
   assign head_link_out.ready = pop;
   assign head_entry          = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

>>> design/bmpw_back.sv
// back: byte sequencer for header, pixel bytes and row padding
`default_nettype none

module bmpw_back (
   input  wire                 clock,
   input  wire                 reset,
   input  bmpw_pkg::link_type  head_link,
   input  bmpw_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [7:0]          rsp_byte,
   output logic                rsp_last,
   output logic                rsp_eof
);
   import bmpw_pkg::*;

   localparam logic [1:0] PH_HDR = 2'd0;
   localparam logic [1:0] PH_PIX = 2'd1;
   localparam logic [1:0] PH_PAD = 2'd2;

   entry_type        cur_ff;
   logic             busy_ff, busy_in;
   logic [1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [RAW_W-1:0] raw_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   logic             out_eof_ff;

   logic             adv;
   logic             last_byte;
   logic             load;
   logic             has_pad;
   logic [7:0]       hdr_byte;
   logic [7:0]       byte_now;
   logic [31:0]      file_size;
   logic [31:0]      word;
   logic [1:0]       lane;

   assign has_pad = cur_ff.row_end && (cur_ff.pad != 2'd0);
   assign adv     = busy_ff && (!out_valid_ff || rsp_ready);

   // final byte of the current pixel
   always_comb begin
      unique case (phase_ff)
         PH_PAD:  last_byte = (idx_ff[1:0] == cur_ff.pad - 2'd1);
         PH_PIX:  last_byte = (idx_ff[1:0] == 2'd2) && !has_pad;
         default: last_byte = 1'b0;
      endcase
   end

   assign load = head_link.valid && (!busy_ff || (adv && last_byte));
   assign pop  = load;

   // pixel data size, registered from the current entry
   always_ff @(posedge clock) begin
      raw_ff <= RAW_W'(cur_ff.stride * cur_ff.height);
   end

   assign file_size = 32'(raw_ff) + HDR_BYTES;

   // header byte selection
   always_comb begin
      word     = '0;
      lane     = 2'd0;
      hdr_byte = 8'h00;
      if (idx_ff >= OFS_FSIZE && idx_ff < OFS_FSIZE + 6'd4) begin
         word = file_size;
         lane = 2'(idx_ff - OFS_FSIZE);
      end else if (idx_ff >= OFS_WIDTH && idx_ff < OFS_WIDTH + 6'd4) begin
         word = 32'(cur_ff.width);
         lane = 2'(idx_ff - OFS_WIDTH);
      end else if (idx_ff >= OFS_HEIGHT && idx_ff < OFS_HEIGHT + 6'd4) begin
         word = 32'(cur_ff.height);
         lane = 2'(idx_ff - OFS_HEIGHT);
      end else if (idx_ff >= OFS_RAW && idx_ff < OFS_RAW + 6'd4) begin
         word = 32'(raw_ff);
         lane = 2'(idx_ff - OFS_RAW);
      end else if (idx_ff >= OFS_XRES && idx_ff < OFS_XRES + 6'd4) begin
         word = RES_PPM;
         lane = 2'(idx_ff - OFS_XRES);
      end else if (idx_ff >= OFS_YRES && idx_ff < OFS_YRES + 6'd4) begin
         word = RES_PPM;
         lane = 2'(idx_ff - OFS_YRES);
      end
      hdr_byte = word[{lane, 3'b000} +: 8];
      if (idx_ff == OFS_MAGIC0) hdr_byte = MAGIC_B;
      else if (idx_ff == OFS_MAGIC1) hdr_byte = MAGIC_M;
      else if (idx_ff == OFS_OFFSET) hdr_byte = DATA_OFS;
      else if (idx_ff == OFS_INFO) hdr_byte = INFO_SIZE;
      else if (idx_ff == OFS_PLANES) hdr_byte = PLANES;
      else if (idx_ff == OFS_BPP) hdr_byte = BITS_PIXEL;
   end

   // byte for the current step
   always_comb begin
      unique case (phase_ff)
         PH_HDR: byte_now = hdr_byte;
         PH_PIX: begin
            case (idx_ff[1:0])
               2'd0:    byte_now = cur_ff.blue;
               2'd1:    byte_now = cur_ff.green;
               default: byte_now = cur_ff.red;
            endcase
         end
         default: byte_now = 8'h00;
      endcase
   end

   // sequencer stepping
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (load) begin
         busy_in  = 1'b1;
         phase_in = head_entry.header ? PH_HDR : PH_PIX;
         idx_in   = '0;
      end else if (adv && last_byte) begin
         busy_in = 1'b0;
      end else if (adv) begin
         unique case (phase_ff)
            PH_HDR: begin
               if (idx_ff == HDR_LAST) begin
                  phase_in = PH_PIX;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_PIX: begin
               if (idx_ff[1:0] == 2'd2) begin
                  phase_in = PH_PAD;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            default: idx_in = idx_ff + IDX_W'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_PIX;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   // current entry
   always_ff @(posedge clock) begin
      if (load) cur_ff <= head_entry;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_byte_ff <= byte_now;
         out_last_ff <= last_byte;
         out_eof_ff  <= last_byte && cur_ff.frame_end;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_eof   = out_eof_ff;

`ifndef SYNTH
   // end of file is only flagged on the last byte of a pixel
   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_eof_ff |-> out_last_ff)
      else $error("end of file without last of run");

   // padding phase only runs for a row end with nonzero padding
   a_pad_needed: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (phase_ff == PH_PAD) |-> has_pad)
      else $error("padding phase without padding");

   // header phase only for an entry that carries the header
   a_hdr_entry: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (phase_ff == PH_HDR) |-> cur_ff.header)
      else $error("header phase for a non-header entry");

   // pixel phase index stays within three bytes
   a_pix_idx: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (phase_ff == PH_PIX) |-> idx_ff < IDX_W'(3))
      else $error("pixel byte index out of range");

   // the queue is only popped while it holds an entry
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_link.ready |-> head_link.valid)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

>>> sim/bmp_stream_checker.sv
// checker: predicts the bmp byte stream from accepted pixels and compares each output byte
`timescale 1ns / 100ps

module bmp_stream_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   input  wire                       req_tready,
   input  wire [23:0]                req_tdata,
   input  wire                       rsp_tvalid,
   input  wire                       rsp_tready,
   input  wire [7:0]                 rsp_tdata,
   input  wire                       rsp_tlast,
   input  wire                       rsp_tuser,
   input  wire                       csr_valid,
   input  wire                       csr_ready,
   input  wire                       csr_index,
   input  wire [bmpw_pkg::DIM_W-1:0] csr_data,
   output logic [31:0]               fail_count,
   output logic [31:0]               pending_bytes
);
   import bmpw_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_file;
   } file_byte_type;

   // bytes of the file still to come, oldest first
   file_byte_type    file_bytes_due [$];

   // shadow registers and frame position
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [COL_W-1:0] col_pos;
   logic [DIM_W-1:0] row_pos;
   logic             header_done;

   // zero acts as one, anything above the maximum as the maximum
   function automatic logic [31:0] fit_dim(input logic [DIM_W-1:0] v);
      if (v == '0)
         return 32'd1;
      if (v > MAX_DIM)
         return 32'(MAX_DIM);
      return 32'(v);
   endfunction

   // work out every byte one pixel adds to the file and queue them
   task automatic add_pixel_bytes(input logic [23:0] px);
      logic [7:0]    run_bytes [60];
      logic [31:0]   w;
      logic [31:0]   h;
      logic [31:0]   pad;
      logic [31:0]   raw;
      logic [31:0]   fsize;
      logic          frame_end;
      file_byte_type fb;
      int            n;
      int            b;
      int            k;
      w = fit_dim(cfg_width);
      h = fit_dim(cfg_height);
      pad = (32'd4 - ((32'd3 * w) & 32'd3)) & 32'd3;
      frame_end = 1'b0;
      n = 0;

      // header at the first pixel of a frame
      if (!header_done) begin
         raw = (32'd3 * w + pad) * h;
         fsize = raw + HDR_BYTES;
         for (k = 0; k <= int'(HDR_LAST); k++)
            run_bytes[k] = 8'h00;
         run_bytes[OFS_MAGIC0] = MAGIC_B;
         run_bytes[OFS_MAGIC1] = MAGIC_M;
         run_bytes[OFS_OFFSET] = DATA_OFS;
         run_bytes[OFS_INFO]   = INFO_SIZE;
         run_bytes[OFS_PLANES] = PLANES;
         run_bytes[OFS_BPP]    = BITS_PIXEL;
         for (b = 0; b < 4; b++) begin
            run_bytes[OFS_FSIZE + b]  = fsize[8*b +: 8];
            run_bytes[OFS_WIDTH + b]  = w[8*b +: 8];
            run_bytes[OFS_HEIGHT + b] = h[8*b +: 8];
            run_bytes[OFS_RAW + b]    = raw[8*b +: 8];
            run_bytes[OFS_XRES + b]   = RES_PPM[8*b +: 8];
            run_bytes[OFS_YRES + b]   = RES_PPM[8*b +: 8];
         end
         n = int'(HDR_LAST) + 1;
         header_done = 1'b1;
      end

      // pixel in b, g, r order
      run_bytes[n]     = px[7:0];
      run_bytes[n + 1] = px[15:8];
      run_bytes[n + 2] = px[23:16];
      n = n + 3;

      // row end: zero pad to a 4-byte boundary, maybe frame end
      if (col_pos + 32'd1 >= w) begin
         for (k = 0; k < int'(pad); k++) begin
            run_bytes[n] = 8'h00;
            n = n + 1;
         end
         col_pos = '0;
         if (row_pos + 32'd1 >= h) begin
            row_pos = '0;
            header_done = 1'b0;
            frame_end = 1'b1;
         end else begin
            row_pos = row_pos + 1'b1;
         end
      end else begin
         col_pos = col_pos + 1'b1;
      end

      for (k = 0; k < n; k++) begin
         fb.out_byte    = run_bytes[k];
         fb.last_of_run = (k == n - 1);
         fb.end_of_file = (k == n - 1) && frame_end;
         file_bytes_due.push_back(fb);
      end
   endtask

   // watch csr, req and rsp transactions
   always @(posedge clock) begin
      file_byte_type want;
      if (reset) begin
         cfg_width = WIDTH_RESET;
         cfg_height = HEIGHT_RESET;
         col_pos = '0;
         row_pos = '0;
         header_done = 1'b0;
         fail_count = 0;
         file_bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               cfg_width = csr_data;
            else
               cfg_height = csr_data;
         end
         if (req_tvalid && req_tready)
            add_pixel_bytes(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (file_bytes_due.size() == 0) begin
               $error("unexpected byte %02h with nothing due", rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               want = file_bytes_due.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_tdata);
                  fail_count = fail_count + 1;
               end
               if (rsp_tlast !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b", want.last_of_run, rsp_tlast);
                  fail_count = fail_count + 1;
               end
               if (rsp_tuser !== want.end_of_file) begin
                  $error("end_of_file: expected %0b, got %0b", want.end_of_file, rsp_tuser);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending_bytes <= file_bytes_due.size();
   end

endmodule

>>> sim/tb_top.sv
// testbench top: pixel stimulus, register writes, receiver stalls and the verdict
`timescale 1ns / 100ps

module tb_top;
   import bmpw_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [23:0]      req_tdata = '0;
   wire              req_tready;
   wire              rsp_tvalid;
   logic             rsp_tready = 1'b0;
   wire  [7:0]       rsp_tdata;
   wire              rsp_tlast;
   wire              rsp_tuser;
   logic             csr_valid = 1'b0;
   logic             csr_index = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0] csr_data = '0;
   wire              csr_ready;
   wire  [31:0]      fail_count;
   wire  [31:0]      pending_bytes;

   int   tx_idle_pct = 0;
   int   rx_stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;

   bmp_24bit_stream_writer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bmp_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_bytes (pending_bytes)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off when asked
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // offer one pixel, valid stays high after the transaction
   task automatic send_pixel(input logic [23:0] px);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // random pixels, with the all-zero and all-one extremes mixed in
   task automatic send_burst(input int count);
      logic [23:0] px;
      int          pick;
      int          i;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            px = 24'h000000;
         else if (pick == 1)
            px = 24'hFFFFFF;
         else
            px = 24'($urandom);
         send_pixel(px);
      end
   endtask

   // stop offering and wait until every byte due has come out
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_bytes != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic idx, input logic [DIM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // write width and/or height while the block is idle
   task automatic set_geometry(input bit wr_w, input logic [DIM_W-1:0] w,
                               input bit wr_h, input logic [DIM_W-1:0] h);
      if (wr_w)
         put_reg(CSR_IMAGE_WIDTH, w);
      if (wr_h)
         put_reg(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // mostly small sizes, sometimes zero, the maximum or beyond it
   function automatic logic [DIM_W-1:0] pick_dim(input int small_top);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return DIM_W'($urandom_range(1, small_top));
      if (roll < 80)
         return DIM_W'($urandom_range(small_top + 1, 20));
      if (roll < 88)
         return '0;
      if (roll < 94)
         return MAX_DIM;
      return DIM_W'($urandom_range(int'(MAX_DIM) + 1, 8191));
   endfunction

   // main stimulus
   initial begin
      int phase;
      int sent;
      int group;
      int mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset geometry, header shows 640 x 480
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h3CA55A);
      // width shrinks mid-row: row ends at once, one pad byte
      settle();
      set_geometry(1'b1, 13'd1, 1'b1, 13'd2);
      send_burst(2);
      // zero sizes act as one: every pixel a whole file
      settle();
      set_geometry(1'b1, 13'd0, 1'b1, 13'd0);
      send_burst(2);
      // oversize values clamp to the maximum in the header
      settle();
      set_geometry(1'b1, 13'h1FFF, 1'b1, 13'h1FFF);
      send_burst(2);
      settle();
      set_geometry(1'b1, MAX_DIM, 1'b1, MAX_DIM);
      send_burst(1);
      // two pad bytes per row
      settle();
      set_geometry(1'b1, 13'd2, 1'b0, '0);
      send_burst(3);
      // three pad bytes, height below the row position ends the frame
      settle();
      set_geometry(1'b1, 13'd3, 1'b1, 13'd1);
      send_burst(3);
      // no padding, fresh small frame
      settle();
      set_geometry(1'b1, 13'd4, 1'b1, 13'd2);
      send_burst(8);

      // random phases with different idle patterns
      for (phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
            default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
         endcase
         sent = 0;
         if (phase == 0) begin
            // long receiver hold-off while pixels keep coming
            set_geometry(1'b1, 13'd5, 1'b1, 13'd3);
            hold_req = ~hold_req;
            send_burst(40);
            sent = 40;
         end
         while (sent < 89) begin
            settle();
            mode = $urandom_range(0, 3);
            set_geometry(mode == 0 || mode == 2, pick_dim(6),
                         mode == 1 || mode == 2, pick_dim(4));
            group = $urandom_range(4, 24);
            send_burst(group);
            sent = sent + group;
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_bytes == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
